[sv/assert_macros.svh]
// Assertion helpers. Empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

[sv/tmt_pkg.sv]
package tmt_pkg;

  localparam int TICK_W  = 31;
  localparam int DUR_W   = 31;
  localparam int TEMPO_W = 24;
  localparam int TPQ_W   = 15;
  localparam int MIN_W   = 32;
  localparam int TIME_W  = 63;
  localparam int DELTA_W = 33;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 128;

  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_LOAD    = 2'd1;
  localparam logic [1:0] OP_BUILD   = 2'd2;
  localparam logic [1:0] OP_CONVERT = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_BUILT = 2'd2;

  localparam logic CFG_TPQ = 1'b0;
  localparam logic CFG_MIN = 1'b1;

  localparam logic [TPQ_W-1:0]   TPQ_RESET     = 15'd480;
  localparam logic [TEMPO_W-1:0] DEFAULT_TEMPO = 24'd500000;

  typedef struct packed {
    logic [1:0]         op;
    logic [TICK_W-1:0]  tick;
    logic [DUR_W-1:0]   dur;
    logic               with_dur;
    logic [TEMPO_W-1:0] tempo;
  } tmt_item_t;

  typedef struct packed {
    logic               go;
    logic [TEMPO_W-1:0] tempo;
    logic [DELTA_W-1:0] delta;
  } tmt_span_req_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

[sv/tmt_front.sv]
module tmt_front import tmt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,
  input  logic [1:0]           s_tuser,
  output logic                 item_valid,
  output tmt_item_t            item,
  input  logic                 pop
);

  tmt_item_t  q [2];
  logic       wp, rp;
  logic [1:0] fill;
  tmt_item_t  unpacked;
  logic       push;

  always_comb begin
    unpacked.op       = s_tuser;
    unpacked.tick     = s_tdata[30:0];
    unpacked.dur      = s_tdata[61:31];
    unpacked.with_dur = s_tdata[62];
    unpacked.tempo    = s_tdata[86:63];
  end

  assign s_tready   = (fill != 2'd2);
  assign push       = s_tvalid && s_tready;
  assign item_valid = (fill != 2'd0);
  assign item       = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= unpacked;
    end
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[sv/tmt_span.sv]
// floor(tempo * delta * 2^FRACTION_BITS / tpq), saturated: shift-add multiply,
// then restoring divide one quotient bit per cycle.
module tmt_span import tmt_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  tmt_span_req_t     req,
  input  logic [TPQ_W-1:0]  tpq,
  output logic              done,
  output logic [TIME_W-1:0] result
);

  localparam int PW = TEMPO_W + DELTA_W;
  localparam int DW = PW + FRACTION_BITS;
  localparam int WW = (DW > TIME_W + 1) ? DW : TIME_W + 1;
  localparam int NW = $clog2(DW + 1);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_MUL  = 2'd1;
  localparam logic [1:0] P_DIV  = 2'd2;

  logic [1:0]         phase;
  logic [NW-1:0]      cnt;
  logic [PW-1:0]      mcand;
  logic [DELTA_W-1:0] mplier;
  logic [DW-1:0]      acc;
  logic [TPQ_W-1:0]   rem;
  logic [TPQ_W:0]     rem2;
  logic               qbit;
  logic [WW-1:0]      ext;

  assign rem2   = {rem, acc[DW-1]};
  assign qbit   = (rem2 >= {1'b0, tpq});
  assign ext    = WW'(acc);
  assign result = (|ext[WW-1:TIME_W]) ? {TIME_W{1'b1}} : ext[TIME_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        P_IDLE: begin
          if (req.go) begin
            mcand  <= PW'(req.tempo);
            mplier <= req.delta;
            acc    <= '0;
            cnt    <= NW'(DELTA_W);
            phase  <= P_MUL;
          end
        end
        P_MUL: begin
          if (cnt == '0) begin
            acc   <= acc << FRACTION_BITS;
            rem   <= '0;
            cnt   <= NW'(DW);
            phase <= P_DIV;
          end else begin
            if (mplier[0]) acc <= acc + DW'(mcand);
            mcand  <= mcand << 1;
            mplier <= mplier >> 1;
            cnt    <= cnt - 1'b1;
          end
        end
        P_DIV: begin
          rem <= qbit ? TPQ_W'(rem2 - {1'b0, tpq}) : rem2[TPQ_W-1:0];
          acc <= {acc[DW-2:0], qbit};
          cnt <= cnt - 1'b1;
          if (cnt == NW'(1)) begin
            phase <= P_IDLE;
            done  <= 1'b1;
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

endmodule

[sv/tmt_back.sv]
module tmt_back import tmt_pkg::*; #(
  parameter int TEMPO_ENTRIES = 64,
  parameter int FRACTION_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  tmt_item_t         item,
  output logic              pop,
  input  logic [TPQ_W-1:0]  tpq,
  input  logic [MIN_W-1:0]  min_dur,
  input  logic              tpq_wr,
  output logic              m_valid,
  input  logic              m_ready,
  output logic [TIME_W-1:0] m_start,
  output logic [TIME_W-1:0] m_dur,
  output logic [1:0]        m_status
);

  localparam int AW   = $clog2(TEMPO_ENTRIES);
  localparam int CW   = $clog2(TEMPO_ENTRIES + 1);
  localparam int TT_W = TICK_W + TEMPO_W;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_LD_CHK  = 4'd1;
  localparam logic [3:0] S_BLD_CHK = 4'd2;
  localparam logic [3:0] S_INS_GO  = 4'd3;
  localparam logic [3:0] S_INS     = 4'd4;
  localparam logic [3:0] S_INS_PUT = 4'd5;
  localparam logic [3:0] S_B0      = 4'd6;
  localparam logic [3:0] S_B1      = 4'd7;
  localparam logic [3:0] S_B2      = 4'd8;
  localparam logic [3:0] S_B3      = 4'd9;
  localparam logic [3:0] S_SC_GO   = 4'd10;
  localparam logic [3:0] S_SC_CMP  = 4'd11;
  localparam logic [3:0] S_SC_GET  = 4'd12;
  localparam logic [3:0] S_SC_SPAN = 4'd13;
  localparam logic [3:0] S_SC_WAIT = 4'd14;
  localparam logic [3:0] S_FIN     = 4'd15;

  // tick/tempo table and segment start times
  logic [TT_W-1:0]   tt_mem  [TEMPO_ENTRIES];
  logic [TIME_W-1:0] seg_mem [TEMPO_ENTRIES];
  logic [TT_W-1:0]   rd_tt;
  logic [TIME_W-1:0] rd_seg;
  logic [TICK_W-1:0] rd_tick;
  logic [TEMPO_W-1:0] rd_tempo;

  logic              tt_we, seg_we, rd_en;
  logic [AW-1:0]     tt_wa, seg_wa, rd_a;
  logic [TT_W-1:0]   tt_wd;
  logic [TIME_W-1:0] seg_wd;

  logic [3:0] state, state_next;
  tmt_item_t  cur, cur_next;
  logic [CW-1:0] count, count_next, pos, pos_next, k, k_next, kp1, pm2;
  logic          map_ready, map_ready_next;
  logic [AW-1:0] best, best_next;
  logic [TICK_W-1:0]  ins_tick, ins_tick_next, prev_tick, prev_tick_next;
  logic [TICK_W-1:0]  cand_tick, cand_tick_next;
  logic [TEMPO_W-1:0] ins_tempo, ins_tempo_next, prev_tempo, prev_tempo_next;
  logic [TEMPO_W-1:0] cand_tempo, cand_tempo_next;
  logic               ins_build, ins_build_next, phase, phase_next;
  logic [TIME_W-1:0]  prev_seg, prev_seg_next, seg_sel, seg_sel_next;
  logic [DELTA_W-1:0] tgt, tgt_next;
  logic [TIME_W-1:0]  res_start, res_start_next, res_dur, res_dur_next;
  logic [1:0]         res_status, res_status_next;
  logic               m_valid_next;
  logic [TIME_W-1:0]  m_start_next, m_dur_next;
  logic [1:0]         m_status_next;
  logic [TIME_W-1:0]  tv, diff;

  tmt_span_req_t     span_req;
  logic              span_done;
  logic [TIME_W-1:0] span_res;

  tmt_span #(.FRACTION_BITS(FRACTION_BITS)) u_span (
    .clk    (clk),
    .rst    (rst),
    .req    (span_req),
    .tpq    (tpq),
    .done   (span_done),
    .result (span_res)
  );

  assign rd_tick  = rd_tt[TT_W-1:TEMPO_W];
  assign rd_tempo = rd_tt[TEMPO_W-1:0];
  assign kp1      = k + 1'b1;
  assign pm2      = pos - CW'(2);
  assign tv       = sat_add(seg_sel, span_res);
  assign diff     = (tv >= res_start) ? tv - res_start : '0;

  always_ff @(posedge clk) begin
    if (tt_we) tt_mem[tt_wa] <= tt_wd;
    if (seg_we) seg_mem[seg_wa] <= seg_wd;
    if (rd_en) begin
      rd_tt  <= tt_mem[rd_a];
      rd_seg <= seg_mem[rd_a];
    end
  end

  always_comb begin
    state_next      = state;
    cur_next        = cur;
    count_next      = count;
    pos_next        = pos;
    k_next          = k;
    map_ready_next  = map_ready;
    best_next       = best;
    ins_tick_next   = ins_tick;
    ins_tempo_next  = ins_tempo;
    ins_build_next  = ins_build;
    prev_tick_next  = prev_tick;
    prev_tempo_next = prev_tempo;
    prev_seg_next   = prev_seg;
    cand_tick_next  = cand_tick;
    cand_tempo_next = cand_tempo;
    seg_sel_next    = seg_sel;
    tgt_next        = tgt;
    phase_next      = phase;
    res_start_next  = res_start;
    res_dur_next    = res_dur;
    res_status_next = res_status;
    m_valid_next    = m_valid && !m_ready;
    m_start_next    = m_start;
    m_dur_next      = m_dur;
    m_status_next   = m_status;
    pop      = 1'b0;
    tt_we    = 1'b0;
    tt_wa    = pos[AW-1:0];
    tt_wd    = {ins_tick, ins_tempo};
    seg_we   = 1'b0;
    seg_wa   = k[AW-1:0];
    seg_wd   = '0;
    rd_en    = 1'b0;
    rd_a     = '0;
    span_req = '{go: 1'b0, tempo: rd_tempo, delta: '0};

    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          pop             = 1'b1;
          cur_next        = item;
          res_start_next  = '0;
          res_dur_next    = '0;
          res_status_next = ST_OK;
          pos_next        = count;
          unique case (item.op)
            OP_CLEAR: begin
              count_next     = '0;
              map_ready_next = 1'b0;
              state_next     = S_FIN;
            end
            OP_LOAD: begin
              map_ready_next = 1'b0;
              ins_tick_next  = item.tick;
              ins_tempo_next = item.tempo;
              ins_build_next = 1'b0;
              if (count < CW'(TEMPO_ENTRIES - 1)) begin
                state_next = S_INS_GO;
              end else if (count == CW'(TEMPO_ENTRIES - 1)) begin
                rd_en      = 1'b1;
                state_next = S_LD_CHK;
              end else begin
                res_status_next = ST_FULL;
                state_next      = S_FIN;
              end
            end
            OP_BUILD: begin
              ins_tick_next  = '0;
              ins_tempo_next = DEFAULT_TEMPO;
              ins_build_next = 1'b1;
              if (count == '0) begin
                state_next = S_INS_GO;
              end else begin
                rd_en      = 1'b1;
                state_next = S_BLD_CHK;
              end
            end
            OP_CONVERT: begin
              if (!map_ready) begin
                res_status_next = ST_NOT_BUILT;
                state_next      = S_FIN;
              end else begin
                tgt_next   = DELTA_W'(item.tick);
                phase_next = 1'b0;
                state_next = S_SC_GO;
              end
            end
            default: state_next = S_FIN;
          endcase
        end
      end
      S_LD_CHK: begin
        if (ins_tick == '0 || rd_tick == '0) begin
          state_next = S_INS_GO;
        end else begin
          res_status_next = ST_FULL;
          state_next      = S_FIN;
        end
      end
      S_BLD_CHK: state_next = (rd_tick != '0) ? S_INS_GO : S_B0;
      S_INS_GO: begin
        if (pos == '0) begin
          state_next = S_INS_PUT;
        end else begin
          rd_en      = 1'b1;
          rd_a       = AW'(pos - 1'b1);
          state_next = S_INS;
        end
      end
      S_INS: begin
        // shift the larger entry up one slot, keep walking down
        if (rd_tick > ins_tick) begin
          tt_we    = 1'b1;
          tt_wd    = rd_tt;
          pos_next = pos - 1'b1;
          if (pos == CW'(1)) begin
            state_next = S_INS_PUT;
          end else begin
            rd_en = 1'b1;
            rd_a  = pm2[AW-1:0];
          end
        end else begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        tt_we      = 1'b1;
        count_next = count + 1'b1;
        state_next = ins_build ? S_B0 : S_FIN;
      end
      S_B0: begin
        rd_en      = 1'b1;
        state_next = S_B1;
      end
      S_B1: begin
        prev_tick_next  = rd_tick;
        prev_tempo_next = rd_tempo;
        prev_seg_next   = '0;
        seg_we          = 1'b1;
        seg_wa          = '0;
        k_next          = CW'(1);
        if (count > CW'(1)) begin
          rd_en      = 1'b1;
          rd_a       = AW'(1);
          state_next = S_B2;
        end else begin
          map_ready_next = 1'b1;
          state_next     = S_FIN;
        end
      end
      S_B2: begin
        span_req.go     = 1'b1;
        span_req.tempo  = prev_tempo;
        span_req.delta  = DELTA_W'(rd_tick - prev_tick);
        cand_tick_next  = rd_tick;
        cand_tempo_next = rd_tempo;
        state_next      = S_B3;
      end
      S_B3: begin
        if (span_done) begin
          seg_we          = 1'b1;
          seg_wd          = sat_add(prev_seg, span_res);
          prev_seg_next   = seg_wd;
          prev_tick_next  = cand_tick;
          prev_tempo_next = cand_tempo;
          k_next          = kp1;
          if (kp1 < count) begin
            rd_en      = 1'b1;
            rd_a       = kp1[AW-1:0];
            state_next = S_B2;
          end else begin
            map_ready_next = 1'b1;
            state_next     = S_FIN;
          end
        end
      end
      S_SC_GO: begin
        best_next = '0;
        k_next    = CW'(1);
        if (count > CW'(1)) begin
          rd_en      = 1'b1;
          rd_a       = AW'(1);
          state_next = S_SC_CMP;
        end else begin
          state_next = S_SC_GET;
        end
      end
      S_SC_CMP: begin
        if (DELTA_W'(rd_tick) <= tgt) best_next = k[AW-1:0];
        k_next = kp1;
        if (kp1 < count) begin
          rd_en = 1'b1;
          rd_a  = kp1[AW-1:0];
        end else begin
          state_next = S_SC_GET;
        end
      end
      S_SC_GET: begin
        rd_en      = 1'b1;
        rd_a       = best;
        state_next = S_SC_SPAN;
      end
      S_SC_SPAN: begin
        span_req.go    = 1'b1;
        span_req.delta = tgt - DELTA_W'(rd_tick);
        seg_sel_next   = rd_seg;
        state_next     = S_SC_WAIT;
      end
      S_SC_WAIT: begin
        if (span_done) begin
          if (!phase) begin
            res_start_next = tv;
            if (cur.with_dur) begin
              tgt_next   = DELTA_W'(cur.tick) + DELTA_W'(cur.dur);
              phase_next = 1'b1;
              state_next = S_SC_GO;
            end else begin
              state_next = S_FIN;
            end
          end else begin
            res_dur_next = (diff > TIME_W'(min_dur)) ? diff : TIME_W'(min_dur);
            state_next   = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!m_valid || m_ready) begin
          m_valid_next  = 1'b1;
          m_start_next  = res_start;
          m_dur_next    = res_dur;
          m_status_next = res_status;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (tpq_wr) map_ready_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    cur        <= cur_next;
    pos        <= pos_next;
    k          <= k_next;
    best       <= best_next;
    ins_tick   <= ins_tick_next;
    ins_tempo  <= ins_tempo_next;
    ins_build  <= ins_build_next;
    prev_tick  <= prev_tick_next;
    prev_tempo <= prev_tempo_next;
    prev_seg   <= prev_seg_next;
    cand_tick  <= cand_tick_next;
    cand_tempo <= cand_tempo_next;
    seg_sel    <= seg_sel_next;
    tgt        <= tgt_next;
    phase      <= phase_next;
    res_start  <= res_start_next;
    res_dur    <= res_dur_next;
    res_status <= res_status_next;
    m_start    <= m_start_next;
    m_dur      <= m_dur_next;
    m_status   <= m_status_next;
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      map_ready <= 1'b0;
      m_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      map_ready <= map_ready_next;
      m_valid   <= m_valid_next;
    end
  end

endmodule

[sv/tempo_map_tick_to_time.sv]
// MIDI tempo map: converts tick times to microseconds with FRACTION_BITS
// fraction bits (saturating at 2^63-1). Each beat on the s_ side carries one
// op in s_tuser: clear, load a tempo change (sorted insert, status 1 when the
// table is full), build (adds a 500000 us/quarter entry at tick 0 if missing
// and computes segment start times), or convert (status 2 until built). Each
// op returns exactly one beat on the m_ side. Items pass a 2-deep queue into
// a sequencer that works one item at a time on a table memory with one read
// port and a shared span unit (shift-add multiply, then a restoring divide
// by ticks-per-quarter). A load walks down the table moving larger entries
// up, with one extra table read when the table is nearly full; a build runs
// the span unit once for each entry after the first, after any tick-0 insert;
// a convert scans the table and runs the span unit, then does both once more
// with a duration. A stalled m_ side holds the sequencer in its last state.
// Config writes are taken every cycle and must only be issued while idle;
// a write to ticks-per-quarter invalidates the built map. A value of 0 for
// ticks-per-quarter behaves as 1.
module tempo_map_tick_to_time import tmt_pkg::*; #(
  parameter int TEMPO_ENTRIES = 64,
  parameter int FRACTION_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // tick[30:0], duration_ticks[61:31], with_duration[62],
  // tempo_us_per_quarter[86:63], zero pad [87]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // op
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // start_time[62:0], duration_time[125:63], zero pad [127:126]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // status
  output logic [1:0]            m_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [MIN_W-1:0]      cfg_data
);

  `include "assert_macros.svh"

  logic [TPQ_W-1:0]  tpq;
  logic [TPQ_W-1:0]  tpq_eff;
  logic [MIN_W-1:0]  min_dur;
  logic              tpq_wr;
  logic              item_valid, pop;
  tmt_item_t         item;
  logic [TIME_W-1:0] out_start, out_dur;

  assign cfg_ready = 1'b1;
  assign tpq_wr    = cfg_valid && (cfg_index == CFG_TPQ);
  assign tpq_eff   = (tpq == '0) ? TPQ_W'(1) : tpq;

  always_ff @(posedge clk) begin
    if (rst) begin
      tpq     <= TPQ_RESET;
      min_dur <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_TPQ) tpq <= cfg_data[TPQ_W-1:0];
      if (cfg_index == CFG_MIN) min_dur <= cfg_data;
    end
  end

  tmt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .item_valid (item_valid),
    .item       (item),
    .pop        (pop)
  );

  tmt_back #(
    .TEMPO_ENTRIES (TEMPO_ENTRIES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .pop        (pop),
    .tpq        (tpq_eff),
    .min_dur    (min_dur),
    .tpq_wr     (tpq_wr),
    .m_valid    (m_tvalid),
    .m_ready    (m_tready),
    .m_start    (out_start),
    .m_dur      (out_dur),
    .m_status   (m_tuser)
  );

  assign m_tdata = {2'b00, out_dur, out_start};

  // rejected ops carry no times
  `ASSERT_IMPLY(a_notbuilt_zero, clk, rst, m_tvalid && m_tuser == ST_NOT_BUILT, m_tdata == '0)
  `ASSERT_IMPLY(a_full_zero, clk, rst, m_tvalid && m_tuser == ST_FULL, m_tdata == '0)
  `ASSERT_IMPLY(a_status_code, clk, rst, m_tvalid, m_tuser <= ST_NOT_BUILT)
  // nothing is popped into the back end while the queue is empty
  `ASSERT_IMPLY(a_pop_valid, clk, rst, pop, item_valid)

endmodule

[tb/sv/tmt_checker.sv]
`timescale 1ns / 1ps

// Watches the config, input and result channels, keeps a model of the
// tempo map and compares every result beat with the oldest prediction.
module tmt_checker import tmt_pkg::*; #(
  parameter int ENTRIES = 64,
  parameter int FRAC    = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [1:0]            s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic [1:0]            m_tuser,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [MIN_W-1:0]      cfg_data,
  output int                    errors,
  output int                    outstanding
);

  localparam longint unsigned TMAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    longint unsigned start_t;
    longint unsigned dur_t;
    logic [1:0]      status;
  } conv_result_t;

  conv_result_t      result_q[$];
  logic [TICK_W-1:0]  map_tick  [ENTRIES];
  logic [TEMPO_W-1:0] map_tempo [ENTRIES];
  longint unsigned    map_start [ENTRIES];
  int                 n_changes;
  bit                 built;
  logic [TPQ_W-1:0]   tpq;
  logic [MIN_W-1:0]   min_dur;

  function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
    return (a > TMAX - b) ? TMAX : a + b;
  endfunction

  // tempo * delta * 2^FRAC / tpq, floored and saturated
  function automatic longint unsigned span_us(logic [TEMPO_W-1:0] tempo,
                                              longint unsigned delta);
    longint unsigned div, prod, q, r, tm;
    div  = (tpq == 0) ? 64'd1 : 64'(tpq);
    tm   = 64'(tempo);
    prod = tm * delta;
    q    = prod / div;
    r    = prod % div;
    if (q > (TMAX >> FRAC)) return TMAX;
    return (q << FRAC) + ((r << FRAC) / div);
  endfunction

  function automatic longint unsigned time_at(longint unsigned t);
    int seg;
    seg = 0;
    for (int k = 1; k < n_changes && k < ENTRIES; k++)
      if (64'(map_tick[k]) <= t) seg = k;
    return sat_sum(map_start[seg], span_us(map_tempo[seg], t - 64'(map_tick[seg])));
  endfunction

  function automatic void insert_change(int pos, logic [TICK_W-1:0] tk,
                                        logic [TEMPO_W-1:0] tp);
    for (int k = n_changes; k > pos; k--) begin
      map_tick[k]  = map_tick[k-1];
      map_tempo[k] = map_tempo[k-1];
    end
    map_tick[pos]  = tk;
    map_tempo[pos] = tp;
    n_changes++;
  endfunction

  function automatic conv_result_t predict(logic [1:0] op, logic [TICK_W-1:0] tk,
                                           logic [DUR_W-1:0] dur, logic wd,
                                           logic [TEMPO_W-1:0] tp);
    conv_result_t    res;
    bit              ok;
    int              pos;
    longint unsigned fin, diff;
    res = '{0, 0, ST_OK};
    case (op)
      OP_CLEAR: begin
        n_changes = 0;
        built = 0;
      end
      OP_LOAD: begin
        built = 0;
        if (n_changes < ENTRIES - 1) ok = 1;
        else if (n_changes == ENTRIES - 1) ok = (tk == 0) || (map_tick[0] == 0);
        else ok = 0;
        if (ok) begin
          pos = n_changes;
          while (pos > 0 && map_tick[pos-1] > tk) pos--;
          insert_change(pos, tk, tp);
        end else begin
          res.status = ST_FULL;
        end
      end
      OP_BUILD: begin
        if (n_changes == 0 || map_tick[0] != 0) insert_change(0, '0, DEFAULT_TEMPO);
        map_start[0] = 0;
        for (int k = 1; k < n_changes && k < ENTRIES; k++)
          map_start[k] = sat_sum(map_start[k-1],
              span_us(map_tempo[k-1], 64'(map_tick[k]) - 64'(map_tick[k-1])));
        built = 1;
      end
      default: begin
        if (!built) begin
          res.status = ST_NOT_BUILT;
        end else begin
          res.start_t = time_at(64'(tk));
          if (wd) begin
            fin  = time_at(64'(tk) + 64'(dur));
            diff = (fin >= res.start_t) ? fin - res.start_t : 0;
            res.dur_t = (diff > 64'(min_dur)) ? diff : 64'(min_dur);
          end
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    conv_result_t exp_r;
    int           nerr;
    nerr = 0;
    if (rst) begin
      n_changes = 0;
      built = 0;
      tpq = TPQ_RESET;
      min_dur = '0;
      result_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TPQ) begin
          tpq = cfg_data[TPQ_W-1:0];
          built = 0;
        end else begin
          min_dur = cfg_data;
        end
      end
      if (s_tvalid && s_tready)
        result_q.insert(result_q.size(),
                        predict(s_tuser, s_tdata[30:0], s_tdata[61:31],
                                s_tdata[62], s_tdata[86:63]));
      if (m_tvalid && m_tready) begin
        if (result_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: start %0d dur %0d status %0d",
                   $time, m_tdata[62:0], m_tdata[125:63], m_tuser);
          nerr++;
        end else begin
          exp_r = result_q.pop_front();
          if (m_tdata[62:0] != exp_r.start_t[62:0]) begin
            $display("%0t: start_time expected %0d actual %0d",
                     $time, exp_r.start_t, m_tdata[62:0]);
            nerr++;
          end
          if (m_tdata[125:63] != exp_r.dur_t[62:0]) begin
            $display("%0t: duration_time expected %0d actual %0d",
                     $time, exp_r.dur_t, m_tdata[125:63]);
            nerr++;
          end
          if (m_tuser != exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, m_tuser);
            nerr++;
          end
        end
      end
    end
    errors <= errors + nerr;
    outstanding <= result_q.size();
  end

endmodule

[tb/sv/tb_tempo_map_tick_to_time.sv]
`timescale 1ns / 1ps

module tb_tempo_map_tick_to_time import tmt_pkg::*; ();

  localparam int ENTRIES   = 64;
  localparam int RUN_ITEMS = 1900;
  // even a full build for every item, at its slowest, would still finish
  // well inside this limit
  localparam int CYCLE_LIMIT = 40_000_000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [1:0]            s_tuser = OP_CLEAR;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0]            m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index = CFG_TPQ;
  logic [MIN_W-1:0]      cfg_data = '0;

  int errors, outstanding;
  int snd_idle = 0;     // percent of cycles the sender holds back
  int rcv_idle = 0;     // percent of cycles the receiver holds back
  int hold_req = 0;     // bump to start a long receiver stall
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;
  int sent = 0;

  always #6 clk = ~clk;

  tempo_map_tick_to_time #(.TEMPO_ENTRIES(ENTRIES), .FRACTION_BITS(8)) u_top (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  tmt_checker #(.ENTRIES(ENTRIES), .FRAC(8)) u_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .errors, .outstanding
  );

  // Receiver: random backpressure, plus a long stall counted here on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 600;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tempo_map_tick_to_time regression: fail");
      $finish;
    end
  end

  // Tick mix: mostly small, some anywhere in range, some at the top.
  function automatic logic [TICK_W-1:0] rnd_tick();
    case ($urandom_range(5))
      0, 1:    return TICK_W'($urandom_range(3000));
      2:       return TICK_W'($urandom_range(200000));
      3:       return TICK_W'($urandom);
      4:       return {TICK_W{1'b1}};
      default: return TICK_W'($urandom_range(40));
    endcase
  endfunction

  function automatic logic [TEMPO_W-1:0] rnd_tempo();
    case ($urandom_range(5))
      0:       return '0;
      1:       return {TEMPO_W{1'b1}};
      2:       return TEMPO_W'($urandom_range(600000, 300000));
      default: return TEMPO_W'($urandom);
    endcase
  endfunction

  // One beat on the input side; valid stays high across back-to-back beats.
  task automatic send(logic [1:0] op, logic [TICK_W-1:0] tk, logic [DUR_W-1:0] dur,
                      logic wd, logic [TEMPO_W-1:0] tp);
    while ($urandom_range(99) < snd_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {1'b0, tp, wd, dur, tk};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic convert_rnd();
    send(OP_CONVERT, rnd_tick(), rnd_tick(), $urandom_range(3) != 0, TEMPO_W'($urandom));
  endtask

  // Stop offering and wait until every expected result is in.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [MIN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int nload;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    repeat (3) @(posedge clk);

    // directed: convert before any build, empty-map build, extremes
    send(OP_CONVERT, '0, '0, 1'b1, '0);
    send(OP_BUILD, '0, '0, 1'b0, '0);
    send(OP_CONVERT, '0, {DUR_W{1'b1}}, 1'b1, '0);
    send(OP_CONVERT, {TICK_W{1'b1}}, {DUR_W{1'b1}}, 1'b1, '0);
    send(OP_CONVERT, 31'd960, 31'd480, 1'b0, '0);
    // equal ticks, zero tempo, max tempo, stale map after a load
    send(OP_CLEAR, '0, '0, 1'b0, '0);
    send(OP_LOAD, 31'd1000, '0, 1'b0, 24'd250000);
    send(OP_LOAD, 31'd1000, '0, 1'b0, 24'd0);
    send(OP_LOAD, 31'd1000, '0, 1'b0, {TEMPO_W{1'b1}});
    send(OP_LOAD, 31'd500, '0, 1'b0, '0);
    send(OP_CONVERT, 31'd700, 31'd10, 1'b1, '0);
    send(OP_BUILD, '0, '0, 1'b0, '0);
    send(OP_CONVERT, 31'd999, 31'd2, 1'b1, '0);
    send(OP_CONVERT, 31'd1000, '0, 1'b1, '0);
    send(OP_CONVERT, 31'd600, 31'd500, 1'b1, '0);
    send(OP_CONVERT, {TICK_W{1'b1}}, {DUR_W{1'b1}}, 1'b1, '0);
    send(OP_LOAD, '0, '0, 1'b0, {TEMPO_W{1'b1}});
    send(OP_BUILD, '0, '0, 1'b0, '0);
    send(OP_CONVERT, {TICK_W{1'b1}}, 31'd1, 1'b1, '0);
    drain();

    // zero ticks-per-quarter acts as one; saturation path
    write_reg(CFG_TPQ, '0);
    write_reg(CFG_MIN, 32'hFFFF_FFFF);
    send(OP_CONVERT, 31'd5, '0, 1'b0, '0);
    send(OP_BUILD, '0, '0, 1'b0, '0);
    convert_rnd();
    send(OP_CONVERT, {TICK_W{1'b1}}, {DUR_W{1'b1}}, 1'b1, '0);
    drain();

    // full table: once starting off tick 0 (tick-0 slot kept), once from tick 0
    write_reg(CFG_TPQ, TPQ_RESET);
    for (int pass = 0; pass < 2; pass++) begin
      send(OP_CLEAR, '0, '0, 1'b0, '0);
      if (pass == 1) send(OP_LOAD, '0, '0, 1'b0, rnd_tempo());
      while (sent < 1000000) begin
        send(OP_LOAD, TICK_W'($urandom_range(5000, 1)), '0, 1'b0, rnd_tempo());
        if ($urandom_range(70) == 0) break;
      end
      repeat (ENTRIES + 2 - pass * 2)
        send(OP_LOAD, TICK_W'($urandom_range(5000, 1)), '0, 1'b0, rnd_tempo());
      send(OP_LOAD, '0, '0, 1'b0, rnd_tempo());
      send(OP_LOAD, TICK_W'($urandom_range(9)), '0, 1'b0, rnd_tempo());
      send(OP_BUILD, '0, '0, 1'b0, '0);
      repeat (6) convert_rnd();
    end
    drain();

    // random part in three idling phases, config changed between phases
    for (int phase = 0; phase < 3; phase++) begin
      drain();
      case (phase)
        0: begin
          write_reg(CFG_TPQ, 15'd1);
          write_reg(CFG_MIN, 32'hFFFF_FFFF);
        end
        1: begin
          write_reg(CFG_TPQ, 15'h7FFF);
          write_reg(CFG_MIN, '0);
        end
        default: begin
          write_reg(CFG_TPQ, TPQ_W'($urandom_range(32767)));
          write_reg(CFG_MIN, MIN_W'($urandom_range(4000)));
        end
      endcase
      snd_idle = (phase == 0) ? 32 : (phase == 1) ? 61 : 0;
      rcv_idle = (phase == 0) ? 61 : (phase == 1) ? 32 : 0;

      if (phase == 0) begin
        // long receiver stall while the sender keeps pushing
        snd_idle = 0;
        hold_req++;
        repeat (24) convert_rnd();
        drain();
        snd_idle = 32;
      end

      while (sent < (RUN_ITEMS * (phase + 1)) / 3 + 60) begin
        if ($urandom_range(99) < 85) begin
          if ($urandom_range(9) < 8) send(OP_CLEAR, rnd_tick(), rnd_tick(), 1'b0, rnd_tempo());
          nload = $urandom_range(6);
          if ($urandom_range(3) == 0)
            send(OP_LOAD, '0, TICK_W'($urandom), 1'b1, rnd_tempo());
          repeat (nload) send(OP_LOAD, rnd_tick(), TICK_W'($urandom), 1'($urandom_range(1)),
                              rnd_tempo());
          if ($urandom_range(15) != 0)
            send(OP_BUILD, rnd_tick(), rnd_tick(), 1'($urandom_range(1)), rnd_tempo());
          repeat ($urandom_range(8, 1)) convert_rnd();
        end else begin
          repeat ($urandom_range(6, 1))
            send(2'($urandom_range(3)), rnd_tick(), rnd_tick(), 1'($urandom_range(1)),
                 rnd_tempo());
        end
      end
    end

    drain();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("tempo_map_tick_to_time regression: pass");
    end else begin
      $display("tempo_map_tick_to_time regression: fail");
    end
    $finish;
  end

endmodule
